// File: design/assert_macros.svh
// Assertion macros shared by the bitmap allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/bscf_pkg.sv
// Shared types and constants of the bitmap allocator.
package bscf_pkg;

  localparam int MAP_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 64;

  localparam int CMD_W = 2;
  localparam int IDX_W = 12;
  localparam int CFG_W = 13;

  localparam logic [CFG_W-1:0] BITS_IN_USE_RST = CFG_W'(4096);

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

// File: design/bscf_req_if.sv
// Command channel of the bitmap allocator.
interface bscf_req_if;
  import bscf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] bit_index;
  logic             bit_value;

  modport source (output valid, command, bit_index, bit_value, input ready);
  modport sink   (input valid, command, bit_index, bit_value, output ready);
endinterface

// File: design/bscf_rsp_if.sv
// Result channel of the bitmap allocator.
interface bscf_rsp_if;
  import bscf_pkg::*;

  logic             valid;
  logic             ready;
  logic             bit_state;
  logic [IDX_W-1:0] free_index;
  logic             found;
  logic             range_error;

  modport source (output valid, bit_state, free_index, found, range_error, input ready);
  modport sink   (input valid, bit_state, free_index, found, range_error, output ready);
endinterface

// File: design/bscf_cfg_if.sv
// Configuration write channel of the bitmap allocator.
interface bscf_cfg_if;
  import bscf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] bits_in_use;

  modport source (output valid, bits_in_use, input ready);
  modport sink   (input valid, bits_in_use, output ready);
endinterface

// File: design/bscf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module bscf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/bitmap_set_check_find_free_core.sv
// Top level of the bitmap allocator: set, check and find-first-zero over a flag map.
//
//   channel   role     fields
//   request   sink     command, bit_index, bit_value
//   response  source   bit_state, free_index, found, range_error
//   cfg       sink     bits_in_use (always ready)
//
// A read or write item reads its word, modifies it and writes it back; its result passes
// through the ST_RMW and ST_RESULT states to the response register, and the next item
// can be accepted once the state machine is back in ST_IDLE.
// A scan reads one map word per cycle from the word holding the start position, at most
// MAP_BITS / WORD_BITS words.
// After reset a clearing pass writes zero to every word while request is held not ready;
// cfg writes are taken.
// A stalled response holds its item; the next request item is still accepted, and its
// result waits in the result stage until the response register frees up.
// WORD_BITS must be a power of two.
`include "assert_macros.svh"

module bitmap_set_check_find_free_core #(
  parameter int MAP_BITS  = bscf_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS = bscf_pkg::WORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  bscf_req_if.sink   request,
  bscf_rsp_if.source response,
  bscf_cfg_if.sink   cfg
);
  import bscf_pkg::*;

  localparam int MapWords = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int OffW     = $clog2(WORD_BITS);
  localparam int LenW     = ($clog2(MAP_BITS + 1) > CFG_W) ? $clog2(MAP_BITS + 1) : CFG_W;
  localparam logic [LenW-1:0]  MapLen   = LenW'(MAP_BITS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MapWords - 1);

  // Lowest set bit of a word; the caller only uses it when the word is non-zero.
  function automatic logic [OffW-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [OffW-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = OffW'(i);
      end
    end
    return p;
  endfunction

  state_t state, state_next;

  // Configuration and control registers.
  logic [CFG_W-1:0] bits_in_use;
  logic [AddrW-1:0] clr_addr;

  // Item registers.
  logic [CMD_W-1:0] cmd;
  logic             val;
  logic [OffW-1:0]  bit_off;
  logic             first;
  logic [AddrW-1:0] word_addr;
  logic [AddrW-1:0] last_word;
  logic [OffW-1:0]  last_off;

  // Result stage.
  logic             res_bit_state;
  logic [IDX_W-1:0] res_free_index;
  logic             res_found;
  logic             res_err;

  // Memory port.
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AddrW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Decode of the item at the request port.
  logic             acc;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  len_m1;
  logic [LenW-1:0]  in_idx;
  logic [AddrW-1:0] in_word;
  logic             in_rw;
  logic             in_scan;
  logic             rw_err;
  logic             scan_err;
  logic             scan_empty;
  logic             range_err_in;

  // Scan and read-modify-write datapath.
  logic [WORD_BITS-1:0] cand;
  logic                 cand_any;
  logic [IDX_W-1:0]     cand_pos;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 out_free;

  bscf_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MapWords)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign request.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign acc           = request.valid && request.ready;
  assign out_free      = !response.valid || response.ready;

  // The effective length is the configured length clamped to the map size.
  assign len     = (LenW'(bits_in_use) > MapLen) ? MapLen : LenW'(bits_in_use);
  assign len_m1  = len - LenW'(1);
  assign in_idx  = LenW'(request.bit_index);
  assign in_word = AddrW'(request.bit_index >> OffW);

  assign in_rw        = (request.command == CMD_WRITE) || (request.command == CMD_READ);
  assign in_scan      = (request.command == CMD_FIND);
  assign rw_err       = in_idx >= len;
  assign scan_err     = in_idx > len;
  assign scan_empty   = in_idx == len;
  assign range_err_in = (in_rw && rw_err) || (in_scan && scan_err);

  // Zero bits of the current word that lie inside the scan window: at or above the
  // start offset in the first word, and below the length in the last word.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      cand[b] = !ram_rdata[b]
              && (!first || (OffW'(b) >= bit_off))
              && ((word_addr != last_word) || (OffW'(b) <= last_off));
    end
  end

  assign cand_any = |cand;
  assign cand_pos = (IDX_W'(word_addr) << OffW) | IDX_W'(first_set(cand));
  assign bit_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_off;

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = word_addr;
    ram_wdata  = val ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
    ram_raddr  = in_word;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LastAddr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // The word of the incoming item is read while it is accepted.
        if (acc) begin
          if (in_rw && !rw_err) begin
            state_next = ST_RMW;
          end else if (in_scan && !scan_err && !scan_empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_RMW: begin
        ram_we     = (cmd == CMD_WRITE);
        state_next = ST_RESULT;
      end
      ST_SCAN: begin
        ram_raddr = word_addr + AddrW'(1);
        if (cand_any || (word_addr == last_word)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      bits_in_use <= BITS_IN_USE_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AddrW'(1);
      end
      if (cfg.valid) begin
        bits_in_use <= cfg.bits_in_use;
      end
    end
  end

  // Item and result registers carry no reset; the state machine qualifies them.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (acc) begin
          cmd            <= request.command;
          val            <= request.bit_value;
          bit_off        <= request.bit_index[OffW-1:0];
          word_addr      <= in_word;
          first          <= 1'b1;
          last_word      <= AddrW'(len_m1 >> OffW);
          last_off       <= len_m1[OffW-1:0];
          res_bit_state  <= 1'b0;
          res_free_index <= '0;
          res_found      <= 1'b0;
          res_err        <= range_err_in;
        end
      end
      ST_RMW: begin
        res_bit_state <= (cmd == CMD_WRITE) ? val : ram_rdata[bit_off];
      end
      ST_SCAN: begin
        first <= 1'b0;
        if (cand_any) begin
          res_found      <= 1'b1;
          res_free_index <= cand_pos;
        end else begin
          word_addr <= word_addr + AddrW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Response register: loaded from the result stage once it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      response.bit_state   <= res_bit_state;
      response.free_index  <= res_free_index;
      response.found       <= res_found;
      response.range_error <= res_err;
    end
  end

  // A scan never walks past the word that holds the last valid bit.
  `ASSERT_IMP(a_scan_bound, clk, rst, state == ST_SCAN, word_addr <= last_word)
  // A found position comes with neither a range error nor a bit state.
  `ASSERT_IMP(a_found_clean, clk, rst, response.valid && response.found,
              !response.range_error && !response.bit_state)
  // An out-of-range item never touches the map.
  `ASSERT_NXT(a_err_direct, clk, rst, acc && range_err_in, state == ST_RESULT && res_err)
  // A found result always lies below the effective length.
  `ASSERT_IMP(a_found_len, clk, rst, state == ST_RESULT && res_found, LenW'(res_free_index) < len)
endmodule

// File: sim/bitmap_set_check_find_free_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the bitmap allocator core: directed steps, then random phases.
module bitmap_set_check_find_free_core_tb;
  import bscf_pkg::*;

  localparam int               CLK_HALF_NS       = 5;
  localparam int               RESET_CYCLES      = 8;
  localparam int               MAP_BITS          = MAP_BITS_DEF;
  localparam int               LAST_INDEX        = (1 << IDX_W) - 1;
  // The package names only the three live commands; the fourth code must be ignored.
  localparam logic [CMD_W-1:0] CMD_UNUSED        = 2'd3;
  localparam int               NUM_STEPS         = 32;
  localparam int               NUM_PHASES        = 9;
  localparam int               PHASE_ITEMS       = 165;
  localparam int               SHORT_PHASE_ITEMS = 40;
  // This outlasts any item in flight, a full scan included.
  localparam int               SETTLE_CYCLES     = 80;
  localparam int               PRINT_CAP         = 40;
  // Leaves a wide margin over the slowest correct run.
  localparam longint           RUN_LIMIT_NS      = 5_000_000;

  // One result item, in the field order of the response channel.
  typedef struct packed {
    logic             bit_state;
    logic [IDX_W-1:0] free_index;
    logic             found;
    logic             range_error;
  } outcome_t;

  // One row of the directed sequence: either a length write or a command item,
  // optionally with its result typed in by hand.
  typedef struct {
    bit               set_length;
    logic [CFG_W-1:0] length;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] bit_index;
    logic             bit_value;
    bit               typed;
    outcome_t         want;
  } step_t;

  localparam outcome_t NOTHING     = '0;
  localparam outcome_t RANGE_FAULT = '{1'b0, 12'd0, 1'b0, 1'b1};
  localparam logic [CMD_W-1:0] LIVE_CMDS [3] = '{CMD_WRITE, CMD_READ, CMD_FIND};

  logic clk;
  logic rst;

  bscf_req_if request_ch ();
  bscf_rsp_if response_ch ();
  bscf_cfg_if cfg_ch ();

  bitmap_set_check_find_free_core uut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch),
    .cfg      (cfg_ch)
  );

  // Our own copy of the flag map and of the length register.
  logic [MAP_BITS-1:0] flag_bits;
  logic [CFG_W-1:0]    length_reg;

  // Results still owed by the block, oldest first.
  outcome_t awaited_results[$];

  int mismatch_count;
  int results_seen;
  int items_sent;
  int scans_sent;
  int frees_found;
  int ranges_hit;
  int length_writes;

  // Sender burst control and the current allocation hot spot.
  int burst_left;
  bit gaps_on;
  int hot_base;

  // Receiver stall pattern state.
  int   ready_run   = 0;
  logic ready_level = 1'b0;
  int   stall_mode  = 0;
  int   mode_cycles = 0;

  always begin
    clk = 1'b0;
    #CLK_HALF_NS;
    clk = 1'b1;
    #CLK_HALF_NS;
  end

  // The effective length is the length register clamped to the map size.
  function automatic int live_length();
    return (length_reg > MAP_BITS) ? MAP_BITS : int'(length_reg);
  endfunction

  // Applies one command to the local map and returns the result the block owes for it.
  function automatic outcome_t map_apply(input logic [CMD_W-1:0] cmd,
                                         input logic [IDX_W-1:0] idx,
                                         input logic val);
    outcome_t res;
    int       len;
    int       pos;
    res = '0;
    len = live_length();
    case (cmd)
      CMD_WRITE, CMD_READ: begin
        // Indexes at or past the length are refused and leave the map alone.
        if (int'(idx) >= len) begin
          res.range_error = 1'b1;
        end else begin
          if (cmd == CMD_WRITE) flag_bits[idx] = val;
          res.bit_state = flag_bits[idx];
        end
      end
      CMD_FIND: begin
        // A start equal to the length is legal and simply examines nothing.
        if (int'(idx) > len) begin
          res.range_error = 1'b1;
        end else begin
          for (pos = int'(idx); pos < len; pos++) begin
            if (!flag_bits[pos]) begin
              res.found      = 1'b1;
              res.free_index = IDX_W'(pos);
              break;
            end
          end
        end
      end
      default: begin
        // The unused code leaves the map untouched and returns all zeros.
      end
    endcase
    return res;
  endfunction

  function automatic outcome_t outcome(input logic st, input int fi, input logic fd,
                                       input logic er);
    return '{st, IDX_W'(fi), fd, er};
  endfunction

  function automatic step_t item_row(input logic [CMD_W-1:0] cmd, input int idx,
                                     input logic val);
    step_t row;
    row.set_length = 1'b0;
    row.length     = '0;
    row.command    = cmd;
    row.bit_index  = IDX_W'(idx);
    row.bit_value  = val;
    row.typed      = 1'b0;
    row.want       = '0;
    return row;
  endfunction

  function automatic step_t checked_row(input logic [CMD_W-1:0] cmd, input int idx,
                                        input logic val, input outcome_t want);
    step_t row;
    row       = item_row(cmd, idx, val);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic step_t length_row(input int n);
    step_t row;
    row            = item_row(CMD_UNUSED, 0, 1'b0);
    row.set_length = 1'b1;
    row.length     = CFG_W'(n);
    return row;
  endfunction

  // Mostly an index in the current hot spot, otherwise anywhere below the length (anywhere at all when it is zero).
  function automatic int near_hot(input int eff);
    int idx;
    if (eff == 0) return $urandom_range(0, LAST_INDEX);
    idx = hot_base + $urandom_range(0, 199);
    if (idx >= eff) idx = $urandom_range(0, eff - 1);
    return idx;
  endfunction

  // Prints one line per mismatch (up to a cap, to keep a broken run readable) and counts it.
  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
                                 input logic [IDX_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("MISMATCH %s at result %0d: got %0d, wanted %0d", what, results_seen, got,
               want);
  endtask

  // Sends one command item. With gaps on, the sender works in bursts: when a burst runs out,
  // valid drops for a random gap before the next item. The expected result is worked out at
  // the edge where the item is accepted, so it sees every earlier item's effect.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic val, input bit typed, input outcome_t typed_want,
                           output outcome_t predicted);
    @(negedge clk);
    if (gaps_on && burst_left <= 0) begin
      request_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    request_ch.valid     <= 1'b1;
    request_ch.command   <= cmd;
    request_ch.bit_index <= idx;
    request_ch.bit_value <= val;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    burst_left--;
    predicted = map_apply(cmd, idx, val);
    awaited_results.push_back(typed ? typed_want : predicted);
    items_sent++;
    if (cmd == CMD_FIND) scans_sent++;
    if (predicted.found) frees_found++;
    if (predicted.range_error) ranges_hit++;
  endtask

  // Writes the length register once the block has returned every result it owes.
  task automatic write_length(input logic [CFG_W-1:0] n);
    @(negedge clk);
    request_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.bits_in_use <= n;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    length_reg = n;
    length_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random phase: set a length, then mostly allocator traffic around a hot spot.
  // An allocation is a scan followed by a write of one at the bit it found, so runs
  // of set bits grow and later scans cross word boundaries and reach the end.
  task automatic random_phase(input int phase);
    logic [CFG_W-1:0] len;
    int               n_items;
    int               eff;
    int               sent;
    int               hot_left;
    int               pick;
    int               idx;
    outcome_t         got;
    outcome_t         unused_res;
    case (phase)
      0:       len = BITS_IN_USE_RST;
      1:       len = CFG_W'($urandom_range(1, MAP_BITS));
      2:       len = CFG_W'($urandom_range(2, 256));
      3:       len = CFG_W'($urandom_range(MAP_BITS + 1, (1 << CFG_W) - 1));
      4:       len = CFG_W'(1);
      5:       len = '0;
      6:       len = CFG_W'($urandom_range(1, 63) * 64 + $urandom_range(0, 2) - 1);
      7:       len = '1;
      default: len = CFG_W'(MAP_BITS - $urandom_range(0, 3));
    endcase
    n_items  = (phase == 4 || phase == 5) ? SHORT_PHASE_ITEMS : PHASE_ITEMS;
    // Every third phase drives back-to-back items with no sender gaps at all.
    gaps_on  = (phase % 3) != 2;
    write_length(len);
    eff      = live_length();
    sent     = 0;
    hot_left = 0;
    while (sent < n_items) begin
      if (hot_left <= 0) begin
        hot_base = (eff == 0) ? 0 : ($urandom_range(0, eff - 1) / 64) * 64;
        hot_left = 60;
      end
      hot_left--;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_item(CMD_FIND, IDX_W'(hot_base), 1'($urandom_range(0, 1)), 1'b0, NOTHING, got);
        sent++;
        if (got.found) begin
          send_item(CMD_WRITE, got.free_index, 1'b1, 1'b0, NOTHING, unused_res);
          sent++;
        end
      end else if (pick < 55) begin
        send_item(CMD_WRITE, IDX_W'(near_hot(eff)), 1'b0, 1'b0, NOTHING, got);
        sent++;
      end else if (pick < 65) begin
        send_item(CMD_READ, IDX_W'(near_hot(eff)), 1'($urandom_range(0, 1)), 1'b0, NOTHING,
                  got);
        sent++;
      end else if (pick < 75) begin
        // The start may equal the length, which must give not found without an error.
        idx = $urandom_range(0, (eff > LAST_INDEX) ? LAST_INDEX : eff);
        send_item(CMD_FIND, IDX_W'(idx), 1'($urandom_range(0, 1)), 1'b0, NOTHING, got);
        sent++;
      end else if (pick < 85) begin
        send_item(CMD_WRITE, IDX_W'($urandom_range(0, LAST_INDEX)),
                  1'($urandom_range(0, 1)), 1'b0, NOTHING, got);
        sent++;
      end else if (pick < 92) begin
        // The unused code is noise and does not count toward the phase.
        send_item(CMD_UNUSED, IDX_W'($urandom_range(0, LAST_INDEX)),
                  1'($urandom_range(0, 1)), 1'b0, NOTHING, got);
      end else begin
        // Indexes at or past the length (anywhere when the length covers every index), for any live command.
        idx = (eff <= LAST_INDEX) ? $urandom_range(eff, LAST_INDEX)
                                  : $urandom_range(0, LAST_INDEX);
        send_item(LIVE_CMDS[$urandom_range(0, 2)], IDX_W'(idx), 1'($urandom_range(0, 1)),
                  1'b0, NOTHING, got);
        sent++;
      end
    end
  endtask

  // The receiver switches between stall patterns: always ready, long ready runs with
  // short stalls, short ready runs with long stalls, or a coin toss each cycle.
  always @(negedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  = $urandom_range(0, 3);
      mode_cycles = $urandom_range(100, 400);
    end else begin
      mode_cycles--;
    end
    if (ready_run > 0) begin
      ready_run--;
    end else begin
      case (stall_mode)
        0: begin
          ready_level = 1'b1;
        end
        1: begin
          ready_level = !ready_level;
          ready_run   = ready_level ? $urandom_range(0, 7) : $urandom_range(0, 2);
        end
        2: begin
          ready_level = !ready_level;
          ready_run   = ready_level ? $urandom_range(0, 1) : $urandom_range(0, 9);
        end
        default: begin
          ready_level = 1'($urandom_range(0, 1));
        end
      endcase
    end
    response_ch.ready <= ready_level;
  end

  // Every accepted result is matched field by field against the oldest expectation.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && response_ch.valid === 1'b1 && response_ch.ready === 1'b1) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited", IDX_W'(1), IDX_W'(0));
      end else begin
        want = awaited_results.pop_front();
        if (response_ch.bit_state !== want.bit_state)
          report_mismatch("bit_state", IDX_W'(response_ch.bit_state),
                          IDX_W'(want.bit_state));
        if (response_ch.free_index !== want.free_index)
          report_mismatch("free_index", response_ch.free_index, want.free_index);
        if (response_ch.found !== want.found)
          report_mismatch("found", IDX_W'(response_ch.found), IDX_W'(want.found));
        if (response_ch.range_error !== want.range_error)
          report_mismatch("range_error", IDX_W'(response_ch.range_error),
                          IDX_W'(want.range_error));
      end
    end
  end

  initial begin : stimulus
    step_t    steps [NUM_STEPS];
    int       k;
    outcome_t got;

    rst                  = 1'b1;
    request_ch.valid     = 1'b0;
    request_ch.command   = CMD_READ;
    request_ch.bit_index = '0;
    request_ch.bit_value = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.bits_in_use   = BITS_IN_USE_RST;
    response_ch.ready    = 1'b0;
    flag_bits            = '0;
    length_reg           = BITS_IN_USE_RST;
    mismatch_count       = 0;
    results_seen         = 0;
    items_sent           = 0;
    scans_sent           = 0;
    frees_found          = 0;
    ranges_hit           = 0;
    length_writes        = 0;
    burst_left           = 0;
    gaps_on              = 1'b1;
    hot_base             = 0;

    // Directed steps. Hand-typed results cover the cleared map, the ends of the index
    // range, the range errors, a scan starting exactly at the length, a scan that finds
    // nothing, a zero length and a length above the map size. The other rows, such as
    // the scan across the first word boundary, go through the predictor.
    steps = '{
      length_row(MAP_BITS),
      checked_row(CMD_READ,   0,    1'b0, NOTHING),
      checked_row(CMD_FIND,   0,    1'b0, outcome(1'b0, 0, 1'b1, 1'b0)),
      checked_row(CMD_WRITE,  0,    1'b1, outcome(1'b1, 0, 1'b0, 1'b0)),
      checked_row(CMD_FIND,   0,    1'b1, outcome(1'b0, 1, 1'b1, 1'b0)),
      checked_row(CMD_WRITE,  4095, 1'b1, outcome(1'b1, 0, 1'b0, 1'b0)),
      checked_row(CMD_FIND,   4095, 1'b0, NOTHING),
      item_row(CMD_WRITE,     63,   1'b1),
      item_row(CMD_FIND,      63,   1'b0),
      checked_row(CMD_UNUSED, 4095, 1'b1, NOTHING),
      item_row(CMD_READ,      4095, 1'b0),
      checked_row(CMD_WRITE,  0,    1'b0, NOTHING),
      length_row(100),
      checked_row(CMD_WRITE,  100,  1'b1, RANGE_FAULT),
      checked_row(CMD_READ,   4095, 1'b0, RANGE_FAULT),
      checked_row(CMD_FIND,   100,  1'b0, NOTHING),
      checked_row(CMD_FIND,   101,  1'b0, RANGE_FAULT),
      item_row(CMD_WRITE,     99,   1'b1),
      checked_row(CMD_FIND,   99,   1'b0, NOTHING),
      length_row(0),
      checked_row(CMD_READ,   0,    1'b0, RANGE_FAULT),
      checked_row(CMD_WRITE,  0,    1'b1, RANGE_FAULT),
      checked_row(CMD_FIND,   0,    1'b0, NOTHING),
      checked_row(CMD_FIND,   1,    1'b0, RANGE_FAULT),
      length_row(1),
      checked_row(CMD_WRITE,  0,    1'b1, outcome(1'b1, 0, 1'b0, 1'b0)),
      checked_row(CMD_FIND,   0,    1'b0, NOTHING),
      checked_row(CMD_FIND,   1,    1'b0, NOTHING),
      length_row((1 << CFG_W) - 1),
      checked_row(CMD_READ,   4095, 1'b0, outcome(1'b1, 0, 1'b0, 1'b0)),
      item_row(CMD_WRITE,     4095, 1'b0),
      checked_row(CMD_FIND,   4095, 1'b0, outcome(1'b0, 4095, 1'b1, 1'b0))
    };

    // Reset is released at a falling edge. The block then runs its clearing pass with
    // request not ready; the first length write goes in during that pass.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < NUM_STEPS; k++) begin
      if (steps[k].set_length) begin
        write_length(steps[k].length);
      end else begin
        send_item(steps[k].command, steps[k].bit_index, steps[k].bit_value, steps[k].typed,
                  steps[k].want, got);
      end
    end

    for (k = 0; k < NUM_PHASES; k++) random_phase(k);

    // Drain: every owed result must arrive, then a quiet spell catches any extra one.
    @(negedge clk);
    request_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results of %0d items: %0d scans, %0d found a free bit, %0d range errors.",
             results_seen, items_sent, scans_sent, frees_found, ranges_hit);
    $display("The length register was written %0d times, from zero up past the map size.",
             length_writes);
    if (mismatch_count == 0) begin
      $display("bitmap_set_check_find_free_core_tb: PASS");
    end else begin
      $display("bitmap_set_check_find_free_core_tb: FAIL");
    end
    $finish;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("bitmap_set_check_find_free_core_tb: FAIL");
    $finish;
  end

endmodule

// File: bitmap_set_check_find_free_core.f
+incdir+design
design/bscf_pkg.sv
design/bscf_req_if.sv
design/bscf_rsp_if.sv
design/bscf_cfg_if.sv
design/bscf_ram.sv
design/bitmap_set_check_find_free_core.sv
sim/bitmap_set_check_find_free_core_tb.sv
